// ----- rtl/pcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants and controller/datapath interface types for the
// percentile contrast stretch block.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int LEVELS    = 256;
  localparam int LVL_W     = 8;
  localparam int PPM_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = 8;

  localparam logic [PPM_W-1:0] PPM_ONE = 20'd1000000;
  localparam logic [PPM_W-1:0] LOW_CUT_RST  = 20'd10;
  localparam logic [PPM_W-1:0] HIGH_CUT_RST = 20'd5000;

  localparam int DEF_MAX_FRAME_PIXELS = 4194304;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT = 1'b1;

  localparam logic OP_ACCUM   = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [LVL_W-1:0] LVL_MIN = 8'd0;
  localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

  typedef struct packed {
    logic cap;
    logic acc_rd;
    logic acc_wr;
    logic scan_init;
    logic scan_rd;
    logic scan_add;
    logic scan_mul;
    logic scan_cmp;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic hit;
    logic idx_end;
    logic dir;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/pcs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: accumulate, histogram scan, division and result hand-off.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  pcs_pkg::sts_t     sts,
  output pcs_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DEC     = 10'b0000000010,
    ST_ACC_RD  = 10'b0000000100,
    ST_ACC_WR  = 10'b0000001000,
    ST_SC_INIT = 10'b0000010000,
    ST_SC_RD   = 10'b0000100000,
    ST_SC_ADD  = 10'b0001000000,
    ST_SC_MUL  = 10'b0010000000,
    ST_SC_CMP  = 10'b0100000000,
    ST_DIV     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;

  assign in_stall = (state_r != ST_IDLE) || emit_r;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    if (emit_r) begin
      if (sts.out_free) begin
        cmd.emit = 1'b1;
        emit_nxt = 1'b0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd.cap   = 1'b1;
            state_nxt = ST_DEC;
          end
        end
        ST_DEC: begin
          if (sts.op == pcs_pkg::OP_STRETCH) begin
            cmd.div_init = 1'b1;
            state_nxt    = ST_DIV;
          end else begin
            cmd.acc_rd = 1'b1;
            state_nxt  = ST_ACC_WR;
          end
        end
        ST_ACC_RD: begin
          cmd.acc_rd = 1'b1;
          state_nxt  = ST_ACC_WR;
        end
        ST_ACC_WR: begin
          cmd.acc_wr = 1'b1;
          state_nxt  = sts.last ? ST_SC_INIT : ST_IDLE;
        end
        ST_SC_INIT: begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SC_RD;
        end
        ST_SC_RD: begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SC_ADD;
        end
        ST_SC_ADD: begin
          cmd.scan_add = 1'b1;
          state_nxt    = ST_SC_MUL;
        end
        ST_SC_MUL: begin
          cmd.scan_mul = 1'b1;
          state_nxt    = ST_SC_CMP;
        end
        ST_SC_CMP: begin
          if (sts.hit || sts.idx_end) begin
            cmd.scan_cmp = 1'b1;
            if (sts.dir) begin
              state_nxt = ST_IDLE;
              emit_nxt  = 1'b1;
            end else begin
              state_nxt = ST_SC_INIT;
            end
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = ST_SC_RD;
          end
        end
        ST_DIV: begin
          cmd.div_step = 1'b1;
          if (sts.div_last) begin
            state_nxt = ST_IDLE;
            emit_nxt  = 1'b1;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pcs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: histogram memory, cut thresholds, level scan, serial divider
// and the output register.
// ----------------------------------------------------------------------------
module pcs_dp #(
  parameter int MAX_FRAME_PIXELS = pcs_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcs_pkg::PPM_W-1:0]       cfg_data,
  input  wire logic                            in_op,
  input  wire logic [pcs_pkg::LVL_W-1:0]       in_pixel_in,
  input  wire logic                            in_last_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_kind,
  output logic [pcs_pkg::LVL_W-1:0]            out_pixel_out,
  output logic [pcs_pkg::LVL_W-1:0]            out_low_level,
  output logic [pcs_pkg::LVL_W-1:0]            out_high_level,
  output logic                                 out_stretch_on,
  input  pcs_pkg::cmd_t                        cmd,
  output pcs_pkg::sts_t                        sts
);

  localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int PROD_W = CNT_W + pcs_pkg::PPM_W;
  localparam int LW     = pcs_pkg::LVL_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);

  logic [pcs_pkg::PPM_W-1:0] low_cut_r, high_cut_r;
  logic                      op_r, last_r;
  logic [LW-1:0]             pix_r;

  logic [CNT_W-1:0]          hist_mem [pcs_pkg::LEVELS];
  logic [pcs_pkg::LEVELS-1:0] valid_r;
  logic [CNT_W-1:0]          rd_q_r;
  logic                      rd_v_r;
  logic [CNT_W-1:0]          rd_val;
  logic [LW-1:0]             rd_addr;

  logic [CNT_W-1:0]          fc_r;
  logic [CNT_W-1:0]          cum_r;
  logic [PROD_W-1:0]         prod_r, thr_r;
  logic [LW-1:0]             idx_r;
  logic                      dir_r;
  logic [LW-1:0]             black_r, white_r;
  logic                      en_r;

  logic [LW:0]               rem_r;
  logic [LW-1:0]             quo_r, dvd_r, den_r;
  logic [2:0]                div_cnt_r;
  logic [2*LW-1:0]           dividend;
  logic [LW:0]               rem_sh;
  logic                      rem_ge;

  logic                      out_valid_r, kind_r, on_r;
  logic [LW-1:0]             pout_r, lo_out_r, hi_out_r;
  logic [LW-1:0]             pix_res;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cut_r  <= pcs_pkg::LOW_CUT_RST;
      high_cut_r <= pcs_pkg::HIGH_CUT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == pcs_pkg::CFG_LOW_CUT)  low_cut_r  <= cfg_data;
      if (cfg_index == pcs_pkg::CFG_HIGH_CUT) high_cut_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      pix_r  <= in_pixel_in;
      last_r <= in_last_pixel;
    end
  end

  // histogram memory
  assign rd_addr = cmd.acc_rd ? pix_r : idx_r;
  assign rd_val  = rd_v_r ? rd_q_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.acc_rd || cmd.scan_rd) rd_q_r <= hist_mem[rd_addr];
    if (cmd.acc_wr && (fc_r < MAX_CNT)) hist_mem[pix_r] <= rd_val + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fc_r    <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (cmd.acc_rd || cmd.scan_rd) rd_v_r <= valid_r[rd_addr];
      if (cmd.emit && (op_r == pcs_pkg::OP_ACCUM)) begin
        valid_r <= '0;
        fc_r    <= '0;
      end else if (cmd.acc_wr && (fc_r < MAX_CNT)) begin
        valid_r[pix_r] <= 1'b1;
        fc_r           <= fc_r + CNT_W'(1);
      end
    end
  end

  // level scan
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cum_r <= '0;
      idx_r <= dir_r ? pcs_pkg::LVL_MAX : pcs_pkg::LVL_MIN;
      thr_r <= PROD_W'(fc_r) * PROD_W'(dir_r ? high_cut_r : low_cut_r);
    end
    if (cmd.scan_add)  cum_r  <= cum_r + rd_val;
    if (cmd.scan_mul)  prod_r <= PROD_W'(cum_r) * PROD_W'(pcs_pkg::PPM_ONE);
    if (cmd.scan_step) idx_r  <= dir_r ? idx_r - LW'(1) : idx_r + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      black_r <= pcs_pkg::LVL_MIN;
      white_r <= pcs_pkg::LVL_MAX;
      en_r    <= 1'b0;
    end else if (cmd.scan_cmp) begin
      dir_r <= ~dir_r;
      if (dir_r) begin
        white_r <= idx_r;
        en_r    <= black_r < idx_r;
      end else begin
        black_r <= idx_r;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign dividend = (2*LW)'(pix_r - black_r) * (2*LW)'(pcs_pkg::LVL_MAX);
  assign rem_sh   = {rem_r[LW-1:0], dvd_r[LW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r     <= {1'b0, dividend[2*LW-1:LW]};
      dvd_r     <= dividend[LW-1:0];
      den_r     <= white_r - black_r;
      quo_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_ge ? rem_sh - {1'b0, den_r} : rem_sh;
      dvd_r     <= {dvd_r[LW-2:0], 1'b0};
      quo_r     <= {quo_r[LW-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + 3'd1;
    end
  end

  always_comb begin
    if (!en_r)                pix_res = pix_r;
    else if (pix_r < black_r) pix_res = pcs_pkg::LVL_MIN;
    else if (pix_r > white_r) pix_res = pcs_pkg::LVL_MAX;
    else                      pix_res = quo_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= (op_r == pcs_pkg::OP_STRETCH) ? pcs_pkg::KIND_PIXEL : pcs_pkg::KIND_REPORT;
      pout_r   <= (op_r == pcs_pkg::OP_STRETCH) ? pix_res : pcs_pkg::LVL_MIN;
      lo_out_r <= black_r;
      hi_out_r <= white_r;
      on_r     <= en_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_pixel_out  = pout_r;
  assign out_low_level  = lo_out_r;
  assign out_high_level = hi_out_r;
  assign out_stretch_on = on_r;

  assign sts.op       = op_r;
  assign sts.last     = last_r;
  assign sts.hit      = prod_r >= thr_r;
  assign sts.idx_end  = dir_r ? (idx_r == pcs_pkg::LVL_MIN) : (idx_r == pcs_pkg::LVL_MAX);
  assign sts.dir      = dir_r;
  assign sts.div_last = div_cnt_r == 3'(pcs_pkg::DIV_STEPS - 1);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// ----- rtl/percentile_contrast_stretch_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_top
// Two-pass 8-bit contrast stretch: histogram pass finds black and white
// levels from percentile cuts, stretch pass remaps pixels between them.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  op, pixel_in, last_pixel
//   out      output     out_valid/out_stall kind, pixel_out, levels, stretch_on
//   cfg      input      cfg_wr_en          cfg_index, cfg_data
//
// accumulate request: histogram read-modify-write (capture, decode and read, write)
// last pixel adds the scan: read, add, multiply, compare per level visited, up to 2 x 256 levels
// stretch request: 8-step serial divider
// histogram clears at once at reset and after each report (valid bits)
// a new request is taken once the previous result is in the output register
// ----------------------------------------------------------------------------
module percentile_contrast_stretch_top #(
  parameter int MAX_FRAME_PIXELS = pcs_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pcs_pkg::PPM_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [pcs_pkg::LVL_W-1:0]     in_pixel_in,
  input  wire logic                          in_last_pixel,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [pcs_pkg::LVL_W-1:0]          out_pixel_out,
  output logic [pcs_pkg::LVL_W-1:0]          out_low_level,
  output logic [pcs_pkg::LVL_W-1:0]          out_high_level,
  output logic                               out_stretch_on
);

  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcs_dp #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_op),
    .in_pixel_in    (in_pixel_in),
    .in_last_pixel  (in_last_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_pixel_out  (out_pixel_out),
    .out_low_level  (out_low_level),
    .out_high_level (out_high_level),
    .out_stretch_on (out_stretch_on),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire
